[hdl/scw_pkg.sv]
// ----------------------------------------------------------------------------
// scw_pkg
// Shared types and constants for the stereo correlation and width unit.
// ----------------------------------------------------------------------------
package scw_pkg;

  localparam int unsigned Log2MaxSamples = 24;
  localparam int unsigned SampleBits     = 16;
  localparam int unsigned CapExp         = 2 * SampleBits - 2 + Log2MaxSamples;

  // Accumulator widths.
  localparam int unsigned LrW = 56;
  localparam int unsigned SqW = 55;
  localparam int unsigned MsW = 57;

  localparam logic [SqW-1:0] ProdCap = SqW'(1) << CapExp;
  localparam logic [MsW-1:0] SqCap   = MsW'(1) << (CapExp + 2);

  localparam int unsigned QueueDepth = 2;

  // Snapshot of the sums at the end of a buffer, handed to the back end.
  typedef struct packed {
    logic           mono;
    logic [LrW-1:0] sum_lr;
    logic [SqW-1:0] sum_ll;
    logic [SqW-1:0] sum_rr;
    logic [MsW-1:0] sum_mid;
    logic [MsW-1:0] sum_side;
  } sums_t;

  typedef struct packed {
    logic [15:0] correlation;
    logic [15:0] stereo_width;
  } result_t;

endpackage

[hdl/stereo_correlation_width_unit.sv]
// ----------------------------------------------------------------------------
// stereo_correlation_width_unit
// Stereo correlation and width meter with stream ports.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle and summed in the front end. A word with
// tlast closes the buffer; its sums go through a two-entry queue to the back
// end, which performs normalization, a bit-serial square root and two
// bit-serial 72-bit divisions before it offers the result word.
// Input stalls only when both queue entries wait for the back end.
module stereo_correlation_width_unit import scw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // mono_input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // left_sample[15:0], right_sample[31:16]
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // correlation[15:0], stereo_width[31:16]
);

  logic mono_q;
  logic snap_v, snap_r, q_v, q_r;
  sums_t snap, qd;
  result_t res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mono_q <= 1'b0;
    else if (cfg_valid_i) mono_q <= cfg_data_i;
  end

  scw_accum u_accum (
    .clk_i, .rst_ni, .mono_i(mono_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .left_i(s_axis_tdata[15:0]), .right_i(s_axis_tdata[31:16]),
    .last_i(s_axis_tlast),
    .snap_valid_o(snap_v), .snap_ready_i(snap_r), .snap_o(snap)
  );

  scw_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(snap_v), .wr_ready_o(snap_r), .wr_data_i(snap),
    .rd_valid_o(q_v), .rd_ready_i(q_r), .rd_data_o(qd)
  );

  scw_solver u_solver (
    .clk_i, .rst_ni,
    .in_valid_i(q_v), .in_ready_o(q_r), .in_i(qd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tdata = {res.stereo_width, res.correlation};

endmodule

[hdl/scw_accum.sv]
// ----------------------------------------------------------------------------
// scw_accum
// Front end: one pair per cycle into the saturating sums, unless held by a
// full queue; emits a snapshot on the last pair of each buffer.
// ----------------------------------------------------------------------------
module scw_accum import scw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mono_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] left_i,
  input  logic [15:0] right_i,
  input  logic        last_i,
  output logic        snap_valid_o,
  input  logic        snap_ready_i,
  output sums_t       snap_o
);

  logic signed [LrW-1:0] lr_q, lr_d;
  logic [SqW-1:0] ll_q, ll_d, rr_q, rr_d;
  logic [MsW-1:0] mid_q, mid_d, side_q, side_d;
  logic signed [SampleBits-1:0] l_s, r_s;
  logic signed [SampleBits:0] sp, sm;
  logic signed [2*SampleBits-1:0] p_lr, p_ll, p_rr;
  logic signed [2*SampleBits+1:0] p_mid, p_side;
  logic signed [LrW-1:0] lr_sum, cap_s;
  logic [SqW:0] ll_sum, rr_sum;
  logic [MsW:0] mid_sum, side_sum;
  logic accept;

  assign l_s = left_i[15 -: SampleBits];
  assign r_s = right_i[15 -: SampleBits];
  assign sp  = {l_s[SampleBits-1], l_s} + {r_s[SampleBits-1], r_s};
  assign sm  = {l_s[SampleBits-1], l_s} - {r_s[SampleBits-1], r_s};

  // Full-width products; the operands are sign-extended to the product width.
  assign p_lr   = l_s * r_s;
  assign p_ll   = l_s * l_s;
  assign p_rr   = r_s * r_s;
  assign p_mid  = sp * sp;
  assign p_side = sm * sm;

  // The front end holds any pair while the queue cannot take a snapshot.
  assign in_ready_o = snap_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cap_s    = LrW'(ProdCap);
  assign lr_sum   = lr_q + LrW'(p_lr);
  assign ll_sum   = {1'b0, ll_q} + (SqW+1)'($unsigned(p_ll));
  assign rr_sum   = {1'b0, rr_q} + (SqW+1)'($unsigned(p_rr));
  assign mid_sum  = {1'b0, mid_q} + (MsW+1)'($unsigned(p_mid));
  assign side_sum = {1'b0, side_q} + (MsW+1)'($unsigned(p_side));

  always_comb begin
    if (lr_sum > cap_s) lr_d = cap_s;
    else if (lr_sum < -cap_s) lr_d = -cap_s;
    else lr_d = lr_sum;
    ll_d   = (ll_sum > (SqW+1)'(ProdCap)) ? ProdCap : ll_sum[SqW-1:0];
    rr_d   = (rr_sum > (SqW+1)'(ProdCap)) ? ProdCap : rr_sum[SqW-1:0];
    mid_d  = (mid_sum > (MsW+1)'(SqCap)) ? SqCap : mid_sum[MsW-1:0];
    side_d = (side_sum > (MsW+1)'(SqCap)) ? SqCap : side_sum[MsW-1:0];
  end

  assign snap_valid_o  = accept && last_i;
  assign snap_o.mono   = mono_i;
  assign snap_o.sum_lr = lr_d;
  assign snap_o.sum_ll = ll_d;
  assign snap_o.sum_rr = rr_d;
  assign snap_o.sum_mid  = mid_d;
  assign snap_o.sum_side = side_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= '0; ll_q <= '0; rr_q <= '0; mid_q <= '0; side_q <= '0;
    end else if (accept) begin
      if (last_i) begin
        lr_q <= '0; ll_q <= '0; rr_q <= '0; mid_q <= '0; side_q <= '0;
      end else begin
        lr_q <= lr_d; ll_q <= ll_d; rr_q <= rr_d; mid_q <= mid_d; side_q <= side_d;
      end
    end
  end

endmodule

[hdl/scw_queue.sv]
// ----------------------------------------------------------------------------
// scw_queue
// Small FIFO of sum snapshots between front and back end.
// ----------------------------------------------------------------------------
module scw_queue import scw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  sums_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output sums_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  sums_t mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth)) else $error("queue count overflow");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PtrW+1)'(QueueDepth) && !rd) |=> cnt_q == (PtrW+1)'(QueueDepth))
    else $error("full queue lost a word");
  a_empty_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && !wr_valid_i) |=> cnt_q == '0) else $error("word invented");
`endif

endmodule

[hdl/scw_solver.sv]
// ----------------------------------------------------------------------------
// scw_solver
// Back end: normalizing shifts, bit-serial square root and two bit-serial
// dividers, one bit per cycle, result held in an output register.
// ----------------------------------------------------------------------------
module scw_solver import scw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sums_t   in_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StNorm  = 4'd1;
  localparam logic [3:0] StMul   = 4'd2;
  localparam logic [3:0] StSqrt  = 4'd3;
  localparam logic [3:0] StDivC  = 4'd4;
  localparam logic [3:0] StDivW  = 4'd5;
  localparam logic [3:0] StOut   = 4'd6;

  logic [3:0] st_q, st_d;
  sums_t s_q;
  logic [SqW-1:0] a_q, b_q;
  logic [5:0] k_q;          // ka + kb
  logic [MsW:0] m_q;
  logic [MsW:0] sd_q;
  logic [59:0] prod_q;      // product of two values below 2^30
  logic [59:0] rem_q;       // sqrt working value
  logic [59:0] root_q;
  logic [61:0] bit_q;
  logic [6:0] cnt_q;
  logic [LrW+15:0] num_q;   // dividend shift register
  logic [60:0] dr_q;        // division remainder
  logic [LrW+15:0] quo_q;
  logic [15:0] corr_q, wid_q;
  logic neg_q, zc_q;

  logic [60:0] dr_shift;
  logic [60:0] dr_next;
  logic [60:0] divisor;
  logic [59:0] trial;
  logic [59:0] rem_cur;
  logic [LrW-1:0] mag;
  logic [LrW+15:0] cq;

  assign in_ready_o  = st_q == StIdle;
  assign out_valid_o = st_q == StOut;
  assign out_o.correlation  = corr_q;
  assign out_o.stereo_width = wid_q;

  assign trial    = root_q + bit_q[59:0];
  assign rem_cur  = (bit_q == 62'(1) << 58) ? prod_q : rem_q;
  assign divisor  = (st_q == StDivC) ? {30'd0, root_q[30:0]} : 61'(m_q);
  assign dr_shift = {dr_q[59:0], num_q[LrW+15]};
  assign dr_next  = (dr_shift >= divisor) ? dr_shift - divisor : dr_shift;
  assign mag      = s_q.sum_lr[LrW-1] ? -s_q.sum_lr : s_q.sum_lr;
  // Quotient including the bit decided in this cycle.
  assign cq       = {quo_q[LrW+14:0], dr_shift >= divisor};

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (in_valid_i) st_d = StNorm;
      StNorm: st_d = ((a_q < SqW'(1 << 30)) && (b_q < SqW'(1 << 30)) &&
                      (m_q < (MsW+1)'(1) << 40)) ? StMul : StNorm;
      StMul:  st_d = StSqrt;
      StSqrt: if (bit_q == '0) st_d = StDivC;
      StDivC: if (cnt_q == '0) st_d = StDivW;
      StDivW: if (cnt_q == '0) st_d = StOut;
      StOut:  if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        s_q  <= in_i;
        a_q  <= in_i.sum_ll;
        b_q  <= in_i.sum_rr;
        k_q  <= '0;
        m_q  <= {1'b0, in_i.sum_mid} + {1'b0, in_i.sum_side};
        sd_q <= {1'b0, in_i.sum_side};
        zc_q <= (in_i.sum_ll == '0) || (in_i.sum_rr == '0);
        neg_q <= in_i.sum_lr[LrW-1];
      end
      StNorm: begin
        // One normalizing step per cycle on each operand.
        if (a_q >= SqW'(1 << 30)) begin
          a_q <= a_q >> 2;
        end
        if (b_q >= SqW'(1 << 30)) begin
          b_q <= b_q >> 2;
        end
        k_q <= k_q + 6'(a_q >= SqW'(1 << 30)) + 6'(b_q >= SqW'(1 << 30));
        if (m_q >= (MsW+1)'(1) << 40) begin
          m_q  <= m_q >> 1;
          sd_q <= sd_q >> 1;
        end
      end
      StMul: begin
        prod_q <= a_q[29:0] * b_q[29:0];
        root_q <= '0;
        bit_q  <= 62'(1) << 58;
      end
      StSqrt: begin
        if (bit_q != '0) begin
          if (rem_cur >= trial) begin
            rem_q  <= rem_cur - trial;
            root_q <= (root_q >> 1) + bit_q[59:0];
          end else begin
            rem_q  <= rem_cur;
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          if (root_q == '0) root_q <= 60'd1;
          num_q <= (LrW+16)'(mag >> k_q) << 15;
          dr_q  <= '0;
          quo_q <= '0;
          cnt_q <= 7'(LrW + 15);
        end
      end
      StDivC: begin
        if (cnt_q == '0) begin
          // Correlation quotient is final with this bit.
          if (s_q.mono || zc_q) corr_q <= 16'd32767;
          else if (neg_q) corr_q <= (cq > 72'd32768) ? 16'h8000 : 16'(-cq[15:0]);
          else corr_q <= (cq > 72'd32767) ? 16'd32767 : cq[15:0];
          num_q <= (LrW+16)'(sd_q[40:0]) << 16;
          dr_q  <= '0;
          quo_q <= '0;
          cnt_q <= 7'(LrW + 15);
        end else begin
          dr_q  <= dr_next;
          quo_q <= cq;
          num_q <= num_q << 1;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      StDivW: begin
        if (cnt_q == '0) begin
          if (s_q.mono || m_q == '0) wid_q <= '0;
          else wid_q <= (cq > 72'd65535) ? 16'hffff : cq[15:0];
        end else begin
          dr_q  <= dr_next;
          quo_q <= cq;
          num_q <= num_q << 1;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

[tb/sv/stereo_correlation_width_unit_tb.sv]
// ----------------------------------------------------------------------------
// stereo_correlation_width_unit_tb
// Self-checking bench: drives stereo pair words with random idling, predicts
// correlation and width per buffer with an integer model, and compares each
// result word in order.
// ----------------------------------------------------------------------------
class scw_scoreboard;
  logic signed [63:0] acc_lr;
  logic [63:0] acc_ll, acc_rr, acc_mid, acc_side;
  bit mono;
  logic [31:0] pending[$];
  int errors;

  function new();
    acc_lr = 0; acc_ll = 0; acc_rr = 0; acc_mid = 0; acc_side = 0;
    mono = 0; errors = 0;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] correlation();
    logic [63:0] a, b, x, d, q;
    int ka, kb;
    bit neg;
    if (acc_ll == 0 || acc_rr == 0) return 16'd32767;
    neg = acc_lr < 0;
    ka = 0; kb = 0;
    while ((acc_ll >> (2 * ka)) >= (64'd1 << 30)) ka++;
    while ((acc_rr >> (2 * kb)) >= (64'd1 << 30)) kb++;
    a = acc_ll >> (2 * ka);
    b = acc_rr >> (2 * kb);
    x = neg ? 64'(-acc_lr) : 64'(acc_lr);
    x = x >> (ka + kb);
    d = isqrt(a * b);
    if (d == 0) d = 1;
    q = (x << 15) / d;
    if (q > 32768) q = 32768;
    if (neg) return 16'(17'h10000 - q);
    return (q > 32767) ? 16'd32767 : q[15:0];
  endfunction

  function automatic logic [15:0] width();
    logic [63:0] m, q;
    int k;
    m = acc_mid + acc_side;
    if (m == 0) return 16'd0;
    k = 0;
    while ((m >> k) >= (64'd1 << 40)) k++;
    q = ((acc_side >> k) << 16) / (m >> k);
    return (q > 65535) ? 16'hffff : q[15:0];
  endfunction

  function automatic logic [63:0] cap_add(logic [63:0] acc, logic [63:0] p, logic [63:0] lim);
    logic [63:0] s;
    s = acc + p;
    return (s > lim) ? lim : s;
  endfunction

  function void note_pair(logic signed [15:0] l, logic signed [15:0] r, bit last);
    logic signed [63:0] lv, rv, cap;
    logic [31:0] want;
    lv = l; rv = r;
    cap = 64'(scw_pkg::ProdCap);
    acc_lr = acc_lr + lv * rv;
    if (acc_lr > cap) acc_lr = cap;
    if (acc_lr < -cap) acc_lr = -cap;
    acc_ll = cap_add(acc_ll, lv * lv, cap);
    acc_rr = cap_add(acc_rr, rv * rv, cap);
    acc_mid = cap_add(acc_mid, (lv + rv) * (lv + rv), 64'(scw_pkg::SqCap));
    acc_side = cap_add(acc_side, (lv - rv) * (lv - rv), 64'(scw_pkg::SqCap));
    if (!last) return;
    if (mono) want = {16'd0, 16'd32767};
    else want = {width(), correlation()};
    pending = {pending, want};
    acc_lr = 0; acc_ll = 0; acc_rr = 0; acc_mid = 0; acc_side = 0;
  endfunction

  function void check_result(logic [31:0] got);
    logic [31:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got[15:0] !== want[15:0]) begin
      $display("%0t: correlation expected %h actual %h", $time, want[15:0], got[15:0]);
      errors++;
    end
    if (got[31:16] !== want[31:16]) begin
      $display("%0t: width expected %h actual %h", $time, want[31:16], got[31:16]);
      errors++;
    end
  endfunction
endclass

module stereo_correlation_width_unit_tb;
  import scw_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic cfg_data_i = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = 0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;

  scw_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  always #10 clk_i = ~clk_i;

  stereo_correlation_width_unit dut (.*);

  // Receiver: random stalls, plus an optional long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The word stays offered until an idle cycle or the next word replaces it.
  task automatic send_pair(logic [15:0] l, logic [15:0] r, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, l};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_pair(l, r, last);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_mono(bit v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.mono = v;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_buffers(int n);
    int len, mode;
    logic [15:0] l, r;
    while (n > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      mode = $urandom_range(4);
      for (int i = 0; i < len; i++) begin
        l = rand_sample();
        case (mode)
          0: r = l;
          1: r = -l;
          2: r = 16'd0;
          default: r = rand_sample();
        endcase
        send_pair(l, r, i == len - 1);
        n--;
      end
    end
  endtask

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes, identical, opposite, silent, one-sided buffers.
    send_pair(16'h7fff, 16'h7fff, 1);
    send_pair(16'h8000, 16'h8000, 1);
    send_pair(16'h8000, 16'h7fff, 1);
    send_pair(16'h7fff, 16'h8000, 1);
    send_pair(16'h0000, 16'h0000, 1);
    send_pair(16'h1234, 16'h0000, 1);
    send_pair(16'h0000, 16'hedcc, 1);
    send_pair(16'h4000, 16'hc000, 0);
    send_pair(16'h0001, 16'hffff, 1);
    send_pair(16'h5555, 16'haaaa, 0);
    send_pair(16'h0000, 16'h0000, 0);
    send_pair(16'hffff, 16'h0001, 1);
    drain();
    write_mono(1);
    send_pair(16'h7fff, 16'h8000, 0);
    send_pair(16'h1000, 16'h2000, 1);
    send_pair(16'h0000, 16'h0000, 1);
    drain();
    write_mono(0);
    random_buffers(250);
    send_idle_pct = 87;
    random_buffers(150);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 87;
    random_buffers(150);
    // Long receiver hold-off with a steady stream of one-pair buffers.
    hold_cycles = 2000;
    recv_stall_pct = 0;
    for (int i = 0; i < 20; i++) send_pair(rand_sample(), rand_sample(), 1);
    drain();
    write_mono(1);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    random_buffers(100);
    drain();
    write_mono(0);
    random_buffers(300);
    drain();
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
